// ===== design/assert_macros.svh =====
// Assertion macros for the calculator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KC8_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kc8 same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define KC8_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kc8 next-cycle check failed");

`endif

// ===== design/kc8_pkg.sv =====
`timescale 1ns / 1ps
package kc8_pkg;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_DONE   = 2'd2
  } kc8_phase_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } kc8_op_e;

  typedef enum logic [2:0] {
    EM_ECHO = 3'd0,
    EM_HUND = 3'd1,
    EM_TENS = 3'd2,
    EM_ONES = 3'd3,
    EM_ERR  = 3'd4,
    EM_CLR  = 3'd5
  } kc8_emit_e;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_DECODE    = 4'd1,
    ST_ECHO      = 4'd2,
    ST_ECHO_MORE = 4'd3,
    ST_CALC      = 4'd4,
    ST_DIV       = 4'd5,
    ST_CONV_H    = 4'd6,
    ST_CONV_T    = 4'd7,
    ST_EMIT_H    = 4'd8,
    ST_EMIT_T    = 4'd9,
    ST_EMIT_O    = 4'd10,
    ST_ERR       = 4'd11,
    ST_CLR       = 4'd12
  } kc8_state_e;

  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_DIGIT   = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_DIVZERO = 2'd3;

  localparam logic [7:0] KEY_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] KEY_SUB   = 8'h2D;  // '-'
  localparam logic [7:0] KEY_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] KEY_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] KEY_EQ    = 8'h3D;  // '='
  localparam logic [7:0] KEY_CLR   = 8'h63;  // 'c'
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'

  typedef struct packed {
    logic      capture;    // latch the key of an accepted request
    logic      decode;     // apply the key to the entry state
    logic      calc;       // compute add, subtract or multiply
    logic      div_start;  // load the divider
    logic      div_step;   // one quotient bit
    logic      conv_h;     // split off the hundreds digit
    logic      conv_t;     // take ten from the remainder
    logic      emit;       // load the output register
    kc8_emit_e emit_sel;
    logic      emit_last;
  } kc8_cmd_t;

  typedef struct packed {
    kc8_phase_e phase;
    kc8_op_e    op;
    logic       key_is_clr;
    logic       second_end;
    logic       divisor_zero;
    logic       div_last;
    logic       rem_ge10;
    logic       hund_nz;
    logic       tens_nz;
    logic       out_free;
  } kc8_status_t;

endpackage

// ===== design/keypad_calculator_8bit.sv =====
`timescale 1ns / 1ps
// Four-function 8-bit calculator that takes one ASCII key per request and
// returns the characters to display. Keys of both numbers are echoed; digits
// build each value as value*10 + (key - '0'), wrapping modulo 256. One of
// + - * / or the KEYS_PER_NUMBER-th key ends the first number, and '=' or
// the KEYS_PER_NUMBER-th key ends the second. If an operator ended the
// first, the wrapped result then follows as one to three decimal digits,
// most significant first (a zero result shows as a single '0', division by
// zero as one item of kind 3). In the done phase 'c' gives one clear-display
// item, any other key gives nothing, and either one starts a new entry. The
// block works on one key at a time: the key request is held off from
// acceptance until every item it causes has been loaded into the output
// register; each item waits for that register to drain. An echo-only key
// goes through the decode and echo states; a key that yields result digits
// also goes through the 8-step restoring divider (for a division) and the
// tens extraction, which subtracts ten once per cycle up to nine times.
module keypad_calculator_8bit #(
  parameter int unsigned KEYS_PER_NUMBER = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic [1:0] char_kind_o,
  output logic       last_of_run_o
);
  import kc8_pkg::*;

  `include "assert_macros.svh"

  // Commands from the sequencer to the datapath, and status back.
  kc8_cmd_t    cmd;
  kc8_status_t status;

  kc8_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // The datapath holds the entry state, the arithmetic, the divider, the
  // decimal conversion and the output register.
  kc8_datapath #(
    .KEYS_PER_NUMBER (KEYS_PER_NUMBER)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_code_i    (key_code_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_char_o    (out_char_o),
    .char_kind_o   (char_kind_o),
    .last_of_run_o (last_of_run_o)
  );

  // Named conditions for the checks below.
  logic in_accept, marker_out, digit_out, digit_ok;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign marker_out = out_valid_o && (char_kind_o == KIND_CLEAR || char_kind_o == KIND_DIVZERO);
  assign digit_out  = out_valid_o && (char_kind_o == KIND_DIGIT);
  assign digit_ok   = (out_char_o >= CHAR_ZERO) && (out_char_o <= CHAR_NINE);

  // After a key request is accepted, the input is held off while the key is decoded.
  `KC8_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_accept, in_stall_o)
  // Clear and error items carry no character and always end the run.
  `KC8_ASSERT_IMP(a_marker_form, clk_i, rst_ni, marker_out, out_char_o == 8'h00 && last_of_run_o)
  // Result digits are decimal characters.
  `KC8_ASSERT_IMP(a_digit_range, clk_i, rst_ni, digit_out, digit_ok)
  // The output register is only loaded when it is free.
  `KC8_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd.emit, status.out_free)

endmodule

// ===== design/kc8_datapath.sv =====
`timescale 1ns / 1ps
module kc8_datapath #(
  parameter int unsigned KEYS_PER_NUMBER = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          key_code_i,
  input  logic                out_stall_i,
  input  kc8_pkg::kc8_cmd_t   cmd_i,
  output kc8_pkg::kc8_status_t status_o,
  output logic                out_valid_o,
  output logic [7:0]          out_char_o,
  output logic [1:0]          char_kind_o,
  output logic                last_of_run_o
);
  import kc8_pkg::*;

  localparam logic [2:0] KeyLimit = 3'(KEYS_PER_NUMBER);

  kc8_phase_e phase_q;
  kc8_op_e    op_q;
  logic [7:0] key_q, first_q, second_q;
  logic [2:0] keys_q;
  logic [7:0] result_q, dq_q, dr_q;
  logic [2:0] dcnt_q;
  logic [1:0] hund_q;
  logic [3:0] tens_q;
  logic [6:0] rem_q;
  logic       out_valid_q, out_last_q;
  logic [7:0] out_char_q;
  logic [1:0] out_kind_q;

  logic [2:0] keys_next;
  logic       num_end, key_is_eq;
  kc8_op_e    key_op;
  logic [7:0] digit_val, first_fold, second_fold, calc_res;
  logic [8:0] div_trial;
  logic       div_ge;
  logic [1:0] hund_d;
  logic [7:0] rem_full;
  logic [7:0] emit_char;
  logic [1:0] emit_kind;

  assign keys_next   = keys_q + 3'd1;
  assign num_end     = (keys_next >= KeyLimit) || (keys_next == 3'd0);
  assign key_is_eq   = (key_q == KEY_EQ);
  assign digit_val   = key_q - CHAR_ZERO;
  assign first_fold  = {first_q[4:0], 3'b000} + {first_q[6:0], 1'b0} + digit_val;
  assign second_fold = {second_q[4:0], 3'b000} + {second_q[6:0], 1'b0} + digit_val;

  always_comb begin
    case (key_q)
      KEY_ADD: key_op = OP_ADD;
      KEY_SUB: key_op = OP_SUB;
      KEY_MUL: key_op = OP_MUL;
      KEY_DIV: key_op = OP_DIV;
      default: key_op = OP_NONE;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_ADD:  calc_res = first_q + second_q;
      OP_SUB:  calc_res = first_q - second_q;
      OP_MUL:  calc_res = 8'(16'(first_q) * 16'(second_q));
      default: calc_res = 8'd0;
    endcase
  end

  // Restoring divider: one quotient bit per step.
  assign div_trial = {dr_q, dq_q[7]};
  assign div_ge    = div_trial >= {1'b0, second_q};

  assign hund_d   = (result_q >= 8'd200) ? 2'd2 : (result_q >= 8'd100) ? 2'd1 : 2'd0;
  assign rem_full = result_q - ((hund_d == 2'd2) ? 8'd200 :
                                (hund_d == 2'd1) ? 8'd100 : 8'd0);

  always_comb begin
    case (cmd_i.emit_sel)
      EM_ECHO: begin
        emit_char = key_q;
        emit_kind = KIND_ECHO;
      end
      EM_HUND: begin
        emit_char = CHAR_ZERO + {6'd0, hund_q};
        emit_kind = KIND_DIGIT;
      end
      EM_TENS: begin
        emit_char = CHAR_ZERO + {4'd0, tens_q};
        emit_kind = KIND_DIGIT;
      end
      EM_ONES: begin
        emit_char = CHAR_ZERO + {1'b0, rem_q};
        emit_kind = KIND_DIGIT;
      end
      EM_ERR: begin
        emit_char = 8'h00;
        emit_kind = KIND_DIVZERO;
      end
      EM_CLR: begin
        emit_char = 8'h00;
        emit_kind = KIND_CLEAR;
      end
      default: begin
        emit_char = 8'h00;
        emit_kind = KIND_ECHO;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      op_q     <= OP_NONE;
      first_q  <= 8'd0;
      second_q <= 8'd0;
      keys_q   <= 3'd0;
    end else if (cmd_i.decode) begin
      case (phase_q)
        PH_FIRST: begin
          if (key_op != OP_NONE) begin
            op_q    <= key_op;
            phase_q <= PH_SECOND;
            keys_q  <= 3'd0;
          end else begin
            first_q <= first_fold;
            if (num_end) begin
              op_q    <= OP_NONE;
              phase_q <= PH_SECOND;
              keys_q  <= 3'd0;
            end else begin
              keys_q <= keys_next;
            end
          end
        end
        PH_SECOND: begin
          if (key_is_eq) begin
            phase_q <= PH_DONE;
            keys_q  <= 3'd0;
          end else begin
            second_q <= second_fold;
            if (num_end) begin
              phase_q <= PH_DONE;
              keys_q  <= 3'd0;
            end else begin
              keys_q <= keys_next;
            end
          end
        end
        default: begin
          phase_q  <= PH_FIRST;
          op_q     <= OP_NONE;
          first_q  <= 8'd0;
          second_q <= 8'd0;
          keys_q   <= 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= key_code_i;
    end
    if (cmd_i.calc) begin
      result_q <= calc_res;
    end
    if (cmd_i.div_start) begin
      dq_q   <= first_q;
      dr_q   <= 8'd0;
      dcnt_q <= 3'd0;
    end else if (cmd_i.div_step) begin
      dq_q   <= {dq_q[6:0], div_ge};
      dr_q   <= div_ge ? 8'(div_trial - {1'b0, second_q}) : div_trial[7:0];
      dcnt_q <= dcnt_q + 3'd1;
      if (dcnt_q == 3'd7) begin
        result_q <= {dq_q[6:0], div_ge};
      end
    end
    if (cmd_i.conv_h) begin
      hund_q <= hund_d;
      rem_q  <= rem_full[6:0];
      tens_q <= 4'd0;
    end else if (cmd_i.conv_t) begin
      rem_q  <= rem_q - 7'd10;
      tens_q <= tens_q + 4'd1;
    end
    if (cmd_i.emit) begin
      out_char_q <= emit_char;
      out_kind_q <= emit_kind;
      out_last_q <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    status_o.phase        = phase_q;
    status_o.op           = op_q;
    status_o.key_is_clr   = (key_q == KEY_CLR);
    status_o.second_end   = key_is_eq || num_end;
    status_o.divisor_zero = (second_q == 8'd0);
    status_o.div_last     = (dcnt_q == 3'd7);
    status_o.rem_ge10     = (rem_q >= 7'd10);
    status_o.hund_nz      = (hund_q != 2'd0);
    status_o.tens_nz      = (tens_q != 4'd0);
    status_o.out_free     = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign char_kind_o   = out_kind_q;
  assign last_of_run_o = out_last_q;

endmodule

// ===== design/kc8_controller.sv =====
`timescale 1ns / 1ps
module kc8_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  kc8_pkg::kc8_status_t status_i,
  output logic                 in_stall_o,
  output kc8_pkg::kc8_cmd_t    cmd_o
);
  import kc8_pkg::*;

  kc8_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        case (status_i.phase)
          PH_FIRST: state_d = ST_ECHO;
          PH_SECOND: begin
            if (status_i.second_end && (status_i.op != OP_NONE)) begin
              state_d = ST_ECHO_MORE;
            end else begin
              state_d = ST_ECHO;
            end
          end
          default: state_d = status_i.key_is_clr ? ST_CLR : ST_IDLE;
        endcase
      end
      ST_ECHO, ST_ECHO_MORE: begin
        cmd_o.emit_sel  = EM_ECHO;
        cmd_o.emit_last = (state_q == ST_ECHO);
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = (state_q == ST_ECHO) ? ST_IDLE : ST_CALC;
        end
      end
      ST_CALC: begin
        case (status_i.op)
          OP_ADD, OP_SUB, OP_MUL: begin
            cmd_o.calc = 1'b1;
            state_d    = ST_CONV_H;
          end
          OP_DIV: begin
            if (status_i.divisor_zero) begin
              state_d = ST_ERR;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = ST_DIV;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_CONV_H;
        end
      end
      ST_CONV_H: begin
        cmd_o.conv_h = 1'b1;
        state_d      = ST_CONV_T;
      end
      ST_CONV_T: begin
        if (status_i.rem_ge10) begin
          cmd_o.conv_t = 1'b1;
        end else if (status_i.hund_nz) begin
          state_d = ST_EMIT_H;
        end else if (status_i.tens_nz) begin
          state_d = ST_EMIT_T;
        end else begin
          state_d = ST_EMIT_O;
        end
      end
      ST_EMIT_H: begin
        cmd_o.emit_sel = EM_HUND;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_EMIT_T;
        end
      end
      ST_EMIT_T: begin
        cmd_o.emit_sel = EM_TENS;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_EMIT_O;
        end
      end
      ST_EMIT_O, ST_ERR, ST_CLR: begin
        cmd_o.emit_last = 1'b1;
        case (state_q)
          ST_EMIT_O: cmd_o.emit_sel = EM_ONES;
          ST_ERR:    cmd_o.emit_sel = EM_ERR;
          default:   cmd_o.emit_sel = EM_CLR;
        endcase
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
